@@ hdl/hle_pkg.sv @@
// shared types and constants for the hex line input editor
// no dependencies; every other file of the block imports this package
package hle_pkg;

   localparam int MAX_DIGITS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int BYTE_W = 8;
   localparam int CNT_W = 4;
   localparam int VALUE_W = 16;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd4;

   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_BS = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_DEL = 8'h7F;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

   typedef enum logic [1:0] {
      CMD_CHAR,
      CMD_ERASE,
      CMD_NEWLINE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [BYTE_W-1:0] ch;
      logic [VALUE_W-1:0] value;
   } cmd_type;

endpackage

@@ hdl/hle_if.sv @@
// valid/ready channel interfaces for requests, responses and the csr write
// depends on hle_pkg
interface hle_req_if;
   import hle_pkg::*;
   logic valid;
   logic ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface hle_rsp_if;
   import hle_pkg::*;
   logic valid;
   logic ready;
   logic [BYTE_W-1:0] echo_byte;
   logic line_done;
   logic [VALUE_W-1:0] entered_value;
   logic last;
   modport source (output valid, output echo_byte, output line_done,
                   output entered_value, output last, input ready);
   modport sink (input valid, input echo_byte, input line_done,
                 input entered_value, input last, output ready);
endinterface

interface hle_csr_if;
   import hle_pkg::*;
   logic valid;
   logic ready;
   logic [CNT_W-1:0] digit_limit;
   modport source (output valid, output digit_limit, input ready);
   modport sink (input valid, input digit_limit, output ready);
endinterface

@@ hdl/hle_front.sv @@
// front end: takes received bytes, classifies them, keeps the line state
// and queues one command per byte that echoes; depends on hle_pkg, hle_if
module hle_front #(
   parameter int MAX_DIGITS = hle_pkg::MAX_DIGITS_DEF
) (
   input  logic clock,
   input  logic reset,
   hle_req_if.sink req,
   hle_csr_if.sink csr,
   input  logic queue_full,
   output logic push,
   output hle_pkg::cmd_type push_cmd
);
   import hle_pkg::*;

   localparam int DIGIT_W = 4 * MAX_DIGITS;

   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [DIGIT_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0] eff_limit;
   logic [VALUE_W-1:0] value_low;
   logic [BYTE_W-1:0] c;
   logic [3:0] nib;
   logic is_hex, is_newline, is_erase, accept;

   generate
      if (DIGIT_W >= VALUE_W) begin : g_wide
         assign value_low = value_ff[VALUE_W-1:0];
      end else begin : g_narrow
         assign value_low = {{(VALUE_W-DIGIT_W){1'b0}}, value_ff};
      end
   endgenerate

   assign c = req.rx_byte;
   assign accept = req.valid && req.ready;
   assign req.ready = !queue_full;
   assign csr.ready = 1'b1;
   assign eff_limit = (limit_ff > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : limit_ff;
   assign is_newline = (c == CHAR_LF) || (c == CHAR_CR);
   assign is_erase = (c == CHAR_BS) || (c == CHAR_DEL);

   always_comb begin
      is_hex = 1'b1;
      nib = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         nib = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         nib = c[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      held_in = held_ff;
      value_in = value_ff;
      limit_in = limit_ff;
      push = 1'b0;
      push_cmd.kind = CMD_CHAR;
      push_cmd.ch = (c >= 8'h61) ? c - CASE_OFFSET : c;
      push_cmd.value = value_low;
      if (csr.valid) begin
         limit_in = csr.digit_limit;
      end
      if (accept) begin
         if (is_newline) begin
            push = 1'b1;
            push_cmd.kind = CMD_NEWLINE;
            held_in = '0;
            value_in = '0;
         end else if (is_erase) begin
            if (held_ff != '0) begin
               push = 1'b1;
               push_cmd.kind = CMD_ERASE;
               held_in = held_ff - 1'b1;
               value_in = value_ff >> 4;
            end
         end else if (is_hex && held_ff < eff_limit) begin
            push = 1'b1;
            held_in = held_ff + 1'b1;
            value_in = DIGIT_W'({value_ff, nib});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         held_ff <= '0;
         value_ff <= '0;
      end else begin
         limit_ff <= limit_in;
         held_ff <= held_in;
         value_ff <= value_in;
      end
   end

endmodule

@@ hdl/hle_cmd_fifo.sv @@
// small register queue of commands between the front and back ends
// depends on hle_pkg
module hle_cmd_fifo #(
   parameter int DEPTH = hle_pkg::QUEUE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  hle_pkg::cmd_type push_cmd,
   input  logic pop,
   output logic full,
   output logic not_empty,
   output hle_pkg::cmd_type head_cmd
);
   import hle_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_FW = $clog2(DEPTH + 1);

   cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_FW-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full = (count_ff == CNT_FW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + CNT_FW'(push) - CNT_FW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ hdl/hle_back.sv @@
// back end: expands each queued command into one to three echo results
// through a registered output stage; depends on hle_pkg, hle_if
module hle_back (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   input  hle_pkg::cmd_type cmd,
   output logic pop,
   hle_rsp_if.source rsp
);
   import hle_pkg::*;

   logic [1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] echo_ff, echo_c;
   logic done_ff, done_c;
   logic [VALUE_W-1:0] value_ff, value_c;
   logic last_ff, last_c;
   logic load;

   always_comb begin
      echo_c = cmd.ch;
      done_c = 1'b0;
      value_c = '0;
      last_c = 1'b1;
      case (cmd.kind)
         CMD_CHAR: begin
            echo_c = cmd.ch;
         end
         CMD_ERASE: begin
            echo_c = (step_ff == 2'd1) ? CHAR_SPACE : CHAR_BS;
            last_c = (step_ff == 2'd2);
         end
         CMD_NEWLINE: begin
            echo_c = (step_ff == 2'd0) ? CHAR_CR : CHAR_LF;
            done_c = (step_ff != 2'd0);
            value_c = (step_ff != 2'd0) ? cmd.value : '0;
            last_c = (step_ff != 2'd0);
         end
         default: begin
            echo_c = cmd.ch;
         end
      endcase
   end

   assign load = cmd_valid && (!rsp_valid_ff || rsp.ready);
   assign pop = load && last_c;
   assign step_in = pop ? 2'd0 : (load ? step_ff + 2'd1 : step_ff);
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);

   assign rsp.valid = rsp_valid_ff;
   assign rsp.echo_byte = echo_ff;
   assign rsp.line_done = done_ff;
   assign rsp.entered_value = value_ff;
   assign rsp.last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         echo_ff <= echo_c;
         done_ff <= done_c;
         value_ff <= value_c;
         last_ff <= last_c;
      end
   end

endmodule

@@ hdl/hex_line_input_editor.sv @@
// hex line input editor: takes terminal bytes on req_bus and returns echo
// transactions on rsp_bus; a csr_bus write sets the digit limit. one byte is
// taken per cycle while the command queue has room. a hex digit, while fewer
// digits than the limit are held, gives one echo transaction, backspace or
// DEL with digits held gives three (bs, space, bs), CR or LF gives two (CR,
// LF) with the line value on the second. other bytes are taken and dropped.
// the response register issues one transaction per cycle while rsp_bus is
// ready; with one to three per item, it is the rate limit of the block.
// depends on hle_pkg, hle_if, hle_front, hle_cmd_fifo, hle_back
module hex_line_input_editor #(
   parameter int MAX_DIGITS = hle_pkg::MAX_DIGITS_DEF,
   parameter int QUEUE_DEPTH = hle_pkg::QUEUE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   hle_req_if.sink req_bus,
   hle_rsp_if.source rsp_bus,
   hle_csr_if.sink csr_bus
);
   import hle_pkg::*;

   // queue handshake between front and back
   logic push, pop, queue_full, queue_not_empty;
   cmd_type push_cmd, head_cmd;

   // front: classify bytes, track held digits and value, queue commands
   hle_front #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .csr(csr_bus),
      .queue_full(queue_full),
      .push(push),
      .push_cmd(push_cmd)
   );

   // decoupling queue so a stalled response side does not block input until it is full
   hle_cmd_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .pop(pop),
      .full(queue_full),
      .not_empty(queue_not_empty),
      .head_cmd(head_cmd)
   );

   // back: expand each command into its echo transactions
   hle_back u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(queue_not_empty),
      .cmd(head_cmd),
      .pop(pop),
      .rsp(rsp_bus)
   );

endmodule

@@ hdl/hle_checker.sv @@
// port level checks of the hex line input editor's response stream
// depends on hle_pkg; bound to hex_line_input_editor
module hle_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_echo_byte,
   input logic rsp_line_done,
   input logic [15:0] rsp_entered_value,
   input logic rsp_last
);
   import hle_pkg::*;

   // a stalled response transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte)
         && $stable(rsp_last) && $stable(rsp_entered_value))
      else $error("response changed while stalled");

   // a completed line always ends on the LF echo as the last transaction
   a_done_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_echo_byte == CHAR_LF && rsp_last)
      else $error("line done without final LF");

   // value is only shown with line done
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_done |-> rsp_entered_value == '0)
      else $error("value outside line done");

   // the space of an erase sequence is followed by its closing backspace
   a_erase_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_echo_byte == CHAR_SPACE |->
         !rsp_last ##1 (rsp_valid && rsp_echo_byte == CHAR_BS && rsp_last)
         || !rsp_valid)
      else $error("erase sequence broken");

endmodule

bind hex_line_input_editor hle_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_echo_byte(rsp_bus.echo_byte),
   .rsp_line_done(rsp_bus.line_done),
   .rsp_entered_value(rsp_bus.entered_value),
   .rsp_last(rsp_bus.last)
);
